// ===== rtl/rbsh_pkg.sv =====
// ============================================================================
// rbsh_pkg - shared types and constants for the rectangle blend hill climber
// Pixel and beat layouts, opcodes, grade width and default image size.
// ============================================================================
package rbsh_pkg;

    // default image size, handed to the top level parameters
    localparam int DEF_IMAGE_WIDTH  = 128;
    localparam int DEF_IMAGE_HEIGHT = 128;

    // grade accumulator width, saturation value and reset grade
    localparam int          GRADE_W     = 24;
    localparam logic [23:0] GRADE_MAX   = 24'hFFFFFF;
    localparam logic [23:0] GRADE_RESET = 24'd9000000;

    // fixed field widths of an item
    localparam int INDEX_W = 14;
    localparam int COORD_W = 7;
    localparam int CHAN_W  = 8;

    typedef enum logic [1:0] {
        OP_LOAD   = 2'd0,
        OP_MUTATE = 2'd1,
        OP_READ   = 2'd2,
        OP_NOP    = 2'd3
    } opcode_t;

    typedef struct packed {
        logic [CHAN_W-1:0] red;
        logic [CHAN_W-1:0] green;
        logic [CHAN_W-1:0] blue;
    } pix_t;

    typedef struct packed {
        opcode_t            opcode;
        logic [INDEX_W-1:0] pixel_index;
        logic [CHAN_W-1:0]  red;
        logic [CHAN_W-1:0]  green;
        logic [CHAN_W-1:0]  blue;
        logic [COORD_W-1:0] rect_x;
        logic [COORD_W-1:0] rect_y;
        logic [COORD_W-1:0] rect_width;
        logic [COORD_W-1:0] rect_height;
    } in_item_t;

    typedef struct packed {
        logic [GRADE_W-1:0] grade;
        logic               accepted;
        logic [CHAN_W-1:0]  best_red;
        logic [CHAN_W-1:0]  best_green;
        logic [CHAN_W-1:0]  best_blue;
    } out_item_t;

    // write enables of the three image stores
    typedef struct packed {
        logic target;
        logic best;
        logic cand;
    } mem_we_t;

endpackage

// ===== rtl/rbsh_pix_alu.sv =====
// ============================================================================
// rbsh_pix_alu - shared pixel arithmetic unit
// Per-channel floor average of two pixels for blending, and the absolute
// channel difference sum added to a saturating grade accumulator.
// ============================================================================
module rbsh_pix_alu (
    input  rbsh_pkg::pix_t                   a,
    input  rbsh_pkg::pix_t                   b,
    input  logic [rbsh_pkg::GRADE_W-1:0]     sum_in,
    output rbsh_pkg::pix_t                   avg,
    output logic [rbsh_pkg::GRADE_W-1:0]     sum_out
);
    import rbsh_pkg::*;

    logic [CHAN_W:0]    red_sum;
    logic [CHAN_W:0]    green_sum;
    logic [CHAN_W:0]    blue_sum;
    logic [CHAN_W-1:0]  red_diff;
    logic [CHAN_W-1:0]  green_diff;
    logic [CHAN_W-1:0]  blue_diff;
    logic [CHAN_W+1:0]  diff_sum;
    logic [GRADE_W:0]   total;

    // floor average per channel
    always_comb
    begin
        red_sum   = {1'b0, a.red}   + {1'b0, b.red};
        green_sum = {1'b0, a.green} + {1'b0, b.green};
        blue_sum  = {1'b0, a.blue}  + {1'b0, b.blue};
        avg.red   = red_sum[CHAN_W:1];
        avg.green = green_sum[CHAN_W:1];
        avg.blue  = blue_sum[CHAN_W:1];
    end

    // absolute differences per channel
    always_comb
    begin
        red_diff   = (a.red   > b.red)   ? (a.red   - b.red)   : (b.red   - a.red);
        green_diff = (a.green > b.green) ? (a.green - b.green) : (b.green - a.green);
        blue_diff  = (a.blue  > b.blue)  ? (a.blue  - b.blue)  : (b.blue  - a.blue);
        diff_sum   = {2'b00, red_diff} + {2'b00, green_diff} + {2'b00, blue_diff};
    end

    // saturating accumulate, at most one pixel past the limit at a time
    always_comb
    begin
        total   = {1'b0, sum_in} + (GRADE_W + 1)'(diff_sum);
        sum_out = total[GRADE_W] ? GRADE_MAX : total[GRADE_W-1:0];
    end

endmodule

// ===== rtl/rbsh_image_store.sv =====
// ============================================================================
// rbsh_image_store - target, best and candidate image memories
// Three single-port-write, single-read memories sharing one read address
// and one write address, with registered read data.
// ============================================================================
module rbsh_image_store #(
    parameter int PIXELS = 16384,
    parameter int ADDR_W = 14
) (
    input  logic                clk,
    input  rbsh_pkg::mem_we_t   we,
    input  logic [ADDR_W-1:0]   wr_addr,
    input  rbsh_pkg::pix_t      target_wdata,
    input  rbsh_pkg::pix_t      best_wdata,
    input  rbsh_pkg::pix_t      cand_wdata,
    input  logic [ADDR_W-1:0]   rd_addr,
    output rbsh_pkg::pix_t      target_q,
    output rbsh_pkg::pix_t      best_q,
    output rbsh_pkg::pix_t      cand_q
);
    import rbsh_pkg::*;

    pix_t target_mem [PIXELS];
    pix_t best_mem   [PIXELS];
    pix_t cand_mem   [PIXELS];

    // target image
    always_ff @(posedge clk)
    begin
        if (we.target)
        begin
            target_mem[wr_addr] <= target_wdata;
        end
        target_q <= target_mem[rd_addr];
    end

    // best image
    always_ff @(posedge clk)
    begin
        if (we.best)
        begin
            best_mem[wr_addr] <= best_wdata;
        end
        best_q <= best_mem[rd_addr];
    end

    // candidate image
    always_ff @(posedge clk)
    begin
        if (we.cand)
        begin
            cand_mem[wr_addr] <= cand_wdata;
        end
        cand_q <= cand_mem[rd_addr];
    end

endmodule

// ===== rtl/rect_blend_sad_hill_climb.sv =====
// ============================================================================
// rect_blend_sad_hill_climb - rectangle blend hill climber over three images
// Sequencer driving the shared pixel unit over the image memories.
// ============================================================================
// After reset the block sweeps all three images to zero, one pixel a cycle,
// over every address, and holds item_stall high meanwhile; the configuration
// register may be written at any time. Items are then taken one at a time.
// A load writes the target image as it is taken and then finishes; a read
// captures the best pixel and then finishes. A mutate reads and then writes
// each blended pixel, steps to the next row at the end of each rectangle row
// inside the image and then leaves the rectangle, then runs a grading sweep
// through the memory read port and, when the candidate beats the kept grade,
// a copy sweep of the candidate into the best image, and then hands over the
// result. A result sits in an output register and the next item is taken
// while it waits; an item finishes only once that register is free.
// ============================================================================
module rect_blend_sad_hill_climb #(
    parameter int IMAGE_WIDTH  = rbsh_pkg::DEF_IMAGE_WIDTH,
    parameter int IMAGE_HEIGHT = rbsh_pkg::DEF_IMAGE_HEIGHT
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          item_valid,
    output logic                          item_stall,
    input  rbsh_pkg::in_item_t            item,
    output logic                          result_valid,
    input  logic                          result_stall,
    output rbsh_pkg::out_item_t           result,
    input  logic                          cfg_write_en,
    input  logic [rbsh_pkg::GRADE_W-1:0]  cfg_write_data
);
    import rbsh_pkg::*;

    localparam int PIXELS     = IMAGE_WIDTH * IMAGE_HEIGHT;
    localparam int ADDR_W     = $clog2(PIXELS);
    localparam int ROW_BASE_W = $clog2(256 * IMAGE_WIDTH);
    localparam logic [ADDR_W-1:0]     LAST_ADDR = ADDR_W'(PIXELS - 1);
    localparam logic [ROW_BASE_W-1:0] ROW_STEP  = ROW_BASE_W'(IMAGE_WIDTH);

    typedef enum logic [10:0] {
        S_CLEAR      = 11'b000_0000_0001,
        S_IDLE       = 11'b000_0000_0010,
        S_BLEND_RD   = 11'b000_0000_0100,
        S_BLEND_WR   = 11'b000_0000_1000,
        S_GRADE      = 11'b000_0001_0000,
        S_GRADE_LAST = 11'b000_0010_0000,
        S_DECIDE     = 11'b000_0100_0000,
        S_COPY       = 11'b000_1000_0000,
        S_COPY_LAST  = 11'b001_0000_0000,
        S_READ_CAP   = 11'b010_0000_0000,
        S_FINISH     = 11'b100_0000_0000
    } state_t;

    // control registers
    state_t                 state_reg,        state_next;
    logic [ADDR_W-1:0]      cnt_reg,          cnt_next;
    logic                   pipe_valid_reg,   pipe_valid_next;
    logic [COORD_W-1:0]     row_cnt_reg,      row_cnt_next;
    logic [COORD_W-1:0]     col_cnt_reg,      col_cnt_next;
    logic [GRADE_W-1:0]     kept_grade_reg,   kept_grade_next;
    logic                   result_valid_reg, result_valid_next;

    // payload registers
    in_item_t               item_reg,         item_next;
    logic [ROW_BASE_W-1:0]  row_base_reg,     row_base_next;
    logic [ADDR_W-1:0]      pix_addr_reg,     pix_addr_next;
    logic [ADDR_W-1:0]      pipe_addr_reg,    pipe_addr_next;
    logic [GRADE_W-1:0]     sum_reg,          sum_next;
    logic                   acc_reg,          acc_next;
    pix_t                   rd_pix_reg,       rd_pix_next;
    out_item_t              result_reg,       result_next;

    // memory and unit signals
    mem_we_t                mem_we;
    logic [ADDR_W-1:0]      wr_addr;
    logic [ADDR_W-1:0]      rd_addr;
    pix_t                   target_wdata;
    pix_t                   best_wdata;
    pix_t                   cand_wdata;
    pix_t                   target_q;
    pix_t                   best_q;
    pix_t                   cand_q;
    pix_t                   alu_a;
    pix_t                   alu_b;
    pix_t                   alu_avg;
    logic [GRADE_W-1:0]     alu_sum;

    // rectangle walk and handshake helpers
    logic                   item_accept;
    logic                   in_index_ok;
    logic                   reg_index_ok;
    logic [ADDR_W-1:0]      in_addr;
    logic [COORD_W:0]       cur_x;
    logic [COORD_W:0]       cur_y;
    logic [ADDR_W-1:0]      cur_addr;
    pix_t                   in_color;
    pix_t                   reg_color;

    assign item_stall   = (state_reg != S_IDLE);
    assign item_accept  = item_valid && !item_stall;
    assign result_valid = result_valid_reg;
    assign result       = result_reg;

    assign in_index_ok  = 32'(item.pixel_index) < 32'(PIXELS);
    assign reg_index_ok = 32'(item_reg.pixel_index) < 32'(PIXELS);
    assign in_addr      = ADDR_W'(item.pixel_index);
    assign in_color     = '{red: item.red, green: item.green, blue: item.blue};
    assign reg_color    = '{red: item_reg.red, green: item_reg.green, blue: item_reg.blue};

    // current rectangle pixel
    assign cur_x    = {1'b0, item_reg.rect_x} + {1'b0, col_cnt_reg};
    assign cur_y    = {1'b0, item_reg.rect_y} + {1'b0, row_cnt_reg};
    assign cur_addr = ADDR_W'(row_base_reg) + ADDR_W'(cur_x);

    // shared unit operands: blend uses best and color, grading target and candidate
    always_comb
    begin
        if (state_reg == S_BLEND_WR)
        begin
            alu_a = best_q;
            alu_b = reg_color;
        end
        else
        begin
            alu_a = target_q;
            alu_b = cand_q;
        end
    end

    rbsh_pix_alu u_alu (
        .a       (alu_a),
        .b       (alu_b),
        .sum_in  (sum_reg),
        .avg     (alu_avg),
        .sum_out (alu_sum)
    );

    rbsh_image_store #(
        .PIXELS (PIXELS),
        .ADDR_W (ADDR_W)
    ) u_store (
        .clk          (clk),
        .we           (mem_we),
        .wr_addr      (wr_addr),
        .target_wdata (target_wdata),
        .best_wdata   (best_wdata),
        .cand_wdata   (cand_wdata),
        .rd_addr      (rd_addr),
        .target_q     (target_q),
        .best_q       (best_q),
        .cand_q       (cand_q)
    );

    // memory write port and read address
    always_comb
    begin
        mem_we       = '0;
        wr_addr      = cnt_reg;
        rd_addr      = cnt_reg;
        target_wdata = (state_reg == S_CLEAR) ? '0 : in_color;
        best_wdata   = (state_reg == S_CLEAR) ? '0 : cand_q;
        cand_wdata   = (state_reg == S_CLEAR) ? '0 : alu_avg;
        case (state_reg)
            S_CLEAR:
            begin
                mem_we = '{target: 1'b1, best: 1'b1, cand: 1'b1};
            end
            S_IDLE:
            begin
                rd_addr = in_addr;
                wr_addr = in_addr;
                mem_we.target = item_accept && (item.opcode == OP_LOAD) && in_index_ok;
            end
            S_BLEND_RD:
            begin
                rd_addr = cur_addr;
            end
            S_BLEND_WR:
            begin
                wr_addr     = pix_addr_reg;
                mem_we.cand = 1'b1;
            end
            S_COPY, S_COPY_LAST:
            begin
                wr_addr     = pipe_addr_reg;
                mem_we.best = pipe_valid_reg;
            end
            default:
            begin
                mem_we = '0;
            end
        endcase
    end

    // sequencer
    always_comb
    begin
        state_next        = state_reg;
        cnt_next          = cnt_reg;
        pipe_valid_next   = 1'b0;
        pipe_addr_next    = cnt_reg;
        row_cnt_next      = row_cnt_reg;
        col_cnt_next      = col_cnt_reg;
        row_base_next     = row_base_reg;
        pix_addr_next     = pix_addr_reg;
        kept_grade_next   = kept_grade_reg;
        item_next         = item_reg;
        sum_next          = sum_reg;
        acc_next          = acc_reg;
        rd_pix_next       = rd_pix_reg;
        result_next       = result_reg;
        result_valid_next = result_valid_reg && result_stall;

        // grading accumulates each pixel in the cycle after its read
        if (pipe_valid_reg && (state_reg inside {S_GRADE, S_GRADE_LAST}))
        begin
            sum_next = alu_sum;
        end

        case (state_reg)
            S_CLEAR:
            begin
                cnt_next = cnt_reg + 1'b1;
                if (cnt_reg == LAST_ADDR)
                begin
                    cnt_next   = '0;
                    state_next = S_IDLE;
                end
            end
            S_IDLE:
            begin
                if (item_accept)
                begin
                    item_next     = item;
                    sum_next      = '0;
                    acc_next      = 1'b0;
                    rd_pix_next   = '0;
                    row_cnt_next  = '0;
                    col_cnt_next  = '0;
                    row_base_next = ROW_BASE_W'(item.rect_y) * ROW_STEP;
                    cnt_next      = '0;
                    case (item.opcode)
                        OP_MUTATE: state_next = S_BLEND_RD;
                        OP_READ:   state_next = S_READ_CAP;
                        default:   state_next = S_FINISH;
                    endcase
                end
            end
            S_BLEND_RD:
            begin
                if ((row_cnt_reg >= item_reg.rect_height) ||
                    (32'(cur_y) >= 32'(IMAGE_HEIGHT)))
                begin
                    cnt_next   = '0;
                    state_next = S_GRADE;
                end
                else if ((col_cnt_reg >= item_reg.rect_width) ||
                         (32'(cur_x) >= 32'(IMAGE_WIDTH)))
                begin
                    row_cnt_next  = row_cnt_reg + 1'b1;
                    col_cnt_next  = '0;
                    row_base_next = row_base_reg + ROW_STEP;
                end
                else
                begin
                    pix_addr_next = cur_addr;
                    state_next    = S_BLEND_WR;
                end
            end
            S_BLEND_WR:
            begin
                col_cnt_next = col_cnt_reg + 1'b1;
                state_next   = S_BLEND_RD;
            end
            S_GRADE:
            begin
                pipe_valid_next = 1'b1;
                cnt_next        = cnt_reg + 1'b1;
                if (cnt_reg == LAST_ADDR)
                begin
                    cnt_next   = '0;
                    state_next = S_GRADE_LAST;
                end
            end
            S_GRADE_LAST:
            begin
                state_next = S_DECIDE;
            end
            S_DECIDE:
            begin
                if (sum_reg < kept_grade_reg)
                begin
                    kept_grade_next = sum_reg;
                    acc_next        = 1'b1;
                    cnt_next        = '0;
                    state_next      = S_COPY;
                end
                else
                begin
                    state_next = S_FINISH;
                end
            end
            S_COPY:
            begin
                pipe_valid_next = 1'b1;
                cnt_next        = cnt_reg + 1'b1;
                if (cnt_reg == LAST_ADDR)
                begin
                    cnt_next   = '0;
                    state_next = S_COPY_LAST;
                end
            end
            S_COPY_LAST:
            begin
                state_next = S_FINISH;
            end
            S_READ_CAP:
            begin
                rd_pix_next = reg_index_ok ? best_q : '0;
                state_next  = S_FINISH;
            end
            S_FINISH:
            begin
                if (!result_valid_reg || !result_stall)
                begin
                    result_next.grade      = sum_reg;
                    result_next.accepted   = acc_reg;
                    result_next.best_red   = rd_pix_reg.red;
                    result_next.best_green = rd_pix_reg.green;
                    result_next.best_blue  = rd_pix_reg.blue;
                    result_valid_next      = 1'b1;
                    state_next             = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase

        // configuration write reloads the kept grade
        if (cfg_write_en)
        begin
            kept_grade_next = cfg_write_data;
        end
    end

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= S_CLEAR;
            cnt_reg          <= '0;
            pipe_valid_reg   <= 1'b0;
            row_cnt_reg      <= '0;
            col_cnt_reg      <= '0;
            kept_grade_reg   <= GRADE_RESET;
            result_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg        <= state_next;
            cnt_reg          <= cnt_next;
            pipe_valid_reg   <= pipe_valid_next;
            row_cnt_reg      <= row_cnt_next;
            col_cnt_reg      <= col_cnt_next;
            kept_grade_reg   <= kept_grade_next;
            result_valid_reg <= result_valid_next;
        end
    end

    // payload
    always_ff @(posedge clk)
    begin
        item_reg      <= item_next;
        row_base_reg  <= row_base_next;
        pix_addr_reg  <= pix_addr_next;
        pipe_addr_reg <= pipe_addr_next;
        sum_reg       <= sum_next;
        acc_reg       <= acc_next;
        rd_pix_reg    <= rd_pix_next;
        result_reg    <= result_next;
    end

endmodule

// ===== tb/sv/hill_climb_checker.sv =====
// ============================================================================
// hill_climb_checker - result scoreboard for the rectangle blend hill climber
// Watches the item, result and configuration ports, keeps its own copy of the
// target, best and candidate images, predicts each result and compares it.
// ============================================================================
module hill_climb_checker (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          item_valid,
    input  logic                          item_stall,
    input  rbsh_pkg::in_item_t            item,
    input  logic                          result_valid,
    input  logic                          result_stall,
    input  rbsh_pkg::out_item_t           result,
    input  logic                          cfg_write_en,
    input  logic [rbsh_pkg::GRADE_W-1:0]  cfg_write_data,
    output int                            mismatch_count,
    output int                            results_owed
);
    import rbsh_pkg::*;

    localparam int IMG_W  = DEF_IMAGE_WIDTH;
    localparam int IMG_H  = DEF_IMAGE_HEIGHT;
    localparam int PIXELS = IMG_W * IMG_H;

    // shadow images and the grade to beat
    pix_t               target_img [PIXELS];
    pix_t               best_img   [PIXELS];
    pix_t               cand_img   [PIXELS];
    logic [GRADE_W-1:0] grade_to_beat;

    // predicted results, oldest first
    out_item_t          owed_results [$];
    out_item_t          want;

    function automatic int unsigned chan_dist(logic [CHAN_W-1:0] a, logic [CHAN_W-1:0] b);
        return (a > b) ? int'(a - b) : int'(b - a);
    endfunction

    function automatic logic [CHAN_W-1:0] blend(logic [CHAN_W-1:0] a, logic [CHAN_W-1:0] b);
        logic [CHAN_W:0] sum;
        sum = {1'b0, a} + {1'b0, b};
        return sum[CHAN_W:1];
    endfunction

    // sum of absolute channel differences, saturating per pixel
    function automatic logic [GRADE_W-1:0] candidate_grade();
        int unsigned sum;
        sum = 0;
        for (int p = 0; p < PIXELS; p++)
        begin
            sum += chan_dist(target_img[p].red, cand_img[p].red);
            sum += chan_dist(target_img[p].green, cand_img[p].green);
            sum += chan_dist(target_img[p].blue, cand_img[p].blue);
            if (sum > GRADE_MAX)
                sum = GRADE_MAX;
        end
        return GRADE_W'(sum);
    endfunction

    // apply one item to the shadow state and return the result it causes
    function automatic out_item_t climb_step(in_item_t it);
        out_item_t res;
        int        x;
        int        y;
        pix_t      old;
        res = '0;
        case (it.opcode)
            OP_LOAD:
            begin
                if (it.pixel_index < PIXELS)
                    target_img[it.pixel_index] = {it.red, it.green, it.blue};
            end
            OP_MUTATE:
            begin
                // blend over the rectangle, clipped at the right and bottom
                for (int i = 0; i < it.rect_height; i++)
                begin
                    y = it.rect_y + i;
                    if (y >= IMG_H)
                        break;
                    for (int j = 0; j < it.rect_width; j++)
                    begin
                        x = it.rect_x + j;
                        if (x >= IMG_W)
                            break;
                        old = best_img[y * IMG_W + x];
                        cand_img[y * IMG_W + x] = {blend(old.red, it.red),
                                                   blend(old.green, it.green),
                                                   blend(old.blue, it.blue)};
                    end
                end
                res.grade = candidate_grade();
                if (res.grade < grade_to_beat)
                begin
                    best_img      = cand_img;
                    grade_to_beat = res.grade;
                    res.accepted  = 1'b1;
                end
            end
            OP_READ:
            begin
                if (it.pixel_index < PIXELS)
                    {res.best_red, res.best_green, res.best_blue} = best_img[it.pixel_index];
            end
            default:
            begin
            end
        endcase
        return res;
    endfunction

    task automatic compare_field(string label, logic [GRADE_W-1:0] want_v,
                                 logic [GRADE_W-1:0] got_v);
        if (got_v !== want_v)
        begin
            $display("%0t: %s expected %0d, got %0d", $time, label, want_v, got_v);
            mismatch_count++;
        end
    endtask

    // sample every port at the rising edge
    always @(posedge clk)
    begin
        if (!rst_n)
        begin
            for (int p = 0; p < PIXELS; p++)
            begin
                target_img[p] = '0;
                best_img[p]   = '0;
                cand_img[p]   = '0;
            end
            grade_to_beat = GRADE_RESET;
            owed_results.delete();
            mismatch_count = 0;
            results_owed   = 0;
        end
        else
        begin
            // a write reloads the grade to beat
            if (cfg_write_en)
                grade_to_beat = cfg_write_data;

            // result beat against the oldest prediction
            if (result_valid && !result_stall)
            begin
                if (owed_results.size() == 0)
                begin
                    $display("%0t: unexpected result beat, expected none, %s %0d %0d %0d %0d %0d",
                             $time, "got grade acc rgb", result.grade, result.accepted,
                             result.best_red, result.best_green, result.best_blue);
                    mismatch_count++;
                end
                else
                begin
                    want = owed_results.pop_front();
                    compare_field("grade", want.grade, result.grade);
                    compare_field("accepted", GRADE_W'(want.accepted), GRADE_W'(result.accepted));
                    compare_field("best_red", GRADE_W'(want.best_red), GRADE_W'(result.best_red));
                    compare_field("best_green", GRADE_W'(want.best_green),
                                  GRADE_W'(result.best_green));
                    compare_field("best_blue", GRADE_W'(want.best_blue),
                                  GRADE_W'(result.best_blue));
                end
            end

            // item beat updates the shadow state
            if (item_valid && !item_stall)
                owed_results.push_back(climb_step(item));

            results_owed = owed_results.size();
        end
    end

endmodule

// ===== tb/sv/tb_rect_blend_sad_hill_climb.sv =====
// ============================================================================
// tb_rect_blend_sad_hill_climb - testbench top for the hill climber
// Drives directed and random load, mutate, read and no-op beats through
// phases of sender idling, receiver stalls and a long receiver hold-off,
// rewrites the starting grade between phases and reports the verdict.
// ============================================================================
module tb_rect_blend_sad_hill_climb;
    import rbsh_pkg::*;

    // time limit, well past the slowest correct run
    localparam longint RUN_LIMIT = 1_000_000_000;

    logic               clk            = 1'b0;
    logic               rst_n          = 1'b0;
    logic               item_valid     = 1'b0;
    logic               item_stall;
    in_item_t           item           = '0;
    logic               result_valid;
    logic               result_stall   = 1'b0;
    out_item_t          result;
    logic               cfg_write_en   = 1'b0;
    logic [GRADE_W-1:0] cfg_write_data = '0;

    int mismatch_count;
    int results_owed;

    // traffic shaping knobs
    int send_idle_pct = 0;
    int stall_pct     = 0;
    int hold_request  = 0;
    int hold_left     = 0;
    int focus_x;
    int focus_y;

    always #10 clk = ~clk;

    rect_blend_sad_hill_climb dut (
        .clk            (clk),
        .rst_n          (rst_n),
        .item_valid     (item_valid),
        .item_stall     (item_stall),
        .item           (item),
        .result_valid   (result_valid),
        .result_stall   (result_stall),
        .result         (result),
        .cfg_write_en   (cfg_write_en),
        .cfg_write_data (cfg_write_data)
    );

    hill_climb_checker u_check (
        .clk            (clk),
        .rst_n          (rst_n),
        .item_valid     (item_valid),
        .item_stall     (item_stall),
        .item           (item),
        .result_valid   (result_valid),
        .result_stall   (result_stall),
        .result         (result),
        .cfg_write_en   (cfg_write_en),
        .cfg_write_data (cfg_write_data),
        .mismatch_count (mismatch_count),
        .results_owed   (results_owed)
    );

    // receiver: long hold-off on request, else random stalls
    always @(negedge clk)
    begin
        if (hold_request > 0)
        begin
            hold_left    = hold_request;
            hold_request = 0;
        end
        if (hold_left > 0)
        begin
            result_stall <= 1'b1;
            hold_left--;
        end
        else
            result_stall <= ($urandom_range(0, 99) < stall_pct);
    end

    // watchdog
    initial
    begin
        #(RUN_LIMIT);
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

    function automatic in_item_t make_item(opcode_t op, int idx, int r, int g, int b,
                                           int x, int y, int w, int h);
        in_item_t it;
        it.opcode      = op;
        it.pixel_index = INDEX_W'(idx);
        it.red         = CHAN_W'(r);
        it.green       = CHAN_W'(g);
        it.blue        = CHAN_W'(b);
        it.rect_x      = COORD_W'(x);
        it.rect_y      = COORD_W'(y);
        it.rect_width  = COORD_W'(w);
        it.rect_height = COORD_W'(h);
        return it;
    endfunction

    // random beat, mostly aimed at a small focus region of the image
    function automatic in_item_t random_item(bit allow_mutate);
        in_item_t it;
        int       pick;
        it = make_item(OP_LOAD, $urandom_range(0, 16383), $urandom_range(0, 255),
                       $urandom_range(0, 255), $urandom_range(0, 255),
                       $urandom_range(0, 127), $urandom_range(0, 127),
                       $urandom_range(0, 127), $urandom_range(0, 127));
        pick = $urandom_range(0, 99);
        if (!allow_mutate && pick >= 45 && pick < 65)
            pick = pick + 20;
        if (pick < 45)
            it.opcode = OP_LOAD;
        else if (pick < 65)
            it.opcode = OP_MUTATE;
        else if (pick < 95)
            it.opcode = OP_READ;
        else
            it.opcode = OP_NOP;

        if (it.opcode == OP_MUTATE)
        begin
            // small rectangles over the focus, now and then a wild one
            if ($urandom_range(0, 9) != 0)
            begin
                it.rect_x      = COORD_W'(focus_x + $urandom_range(0, 8));
                it.rect_y      = COORD_W'(focus_y + $urandom_range(0, 8));
                it.rect_width  = COORD_W'($urandom_range(0, 12));
                it.rect_height = COORD_W'($urandom_range(0, 12));
            end
        end
        else if ($urandom_range(0, 2) != 0)
            it.pixel_index = INDEX_W'(((focus_y + $urandom_range(0, 15)) % 128) * 128
                                      + ((focus_x + $urandom_range(0, 15)) % 128));
        return it;
    endfunction

    // offer one beat after a random gap, hold it until taken
    task automatic send_item(in_item_t it);
        int gap;
        gap = 0;
        while ($urandom_range(0, 99) < send_idle_pct)
            gap++;
        if (gap > 0)
        begin
            item_valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        item       <= it;
        item_valid <= 1'b1;
        do
            @(posedge clk);
        while (item_stall);
        @(negedge clk);
    endtask

    task automatic run_random(int count, bit allow_mutate);
        repeat (count) send_item(random_item(allow_mutate));
    endtask

    // stop offering and wait for every owed result
    task automatic drain_results();
        item_valid <= 1'b0;
        while (results_owed != 0)
            @(negedge clk);
    endtask

    task automatic write_grade(logic [GRADE_W-1:0] value);
        cfg_write_data <= value;
        cfg_write_en   <= 1'b1;
        @(negedge clk);
        cfg_write_en   <= 1'b0;
    endtask

    // stimulus
    initial
    begin
        repeat (9) @(negedge clk);
        rst_n <= 1'b1;
        focus_x = $urandom_range(0, 119);
        focus_y = $urandom_range(0, 119);

        // directed beats, no idling
        send_item(make_item(OP_READ, 0, 0, 0, 0, 0, 0, 0, 0));
        send_item(make_item(OP_NOP, 16383, 255, 255, 255, 127, 127, 127, 127));
        send_item(make_item(OP_LOAD, 0, 255, 255, 255, 0, 0, 0, 0));
        send_item(make_item(OP_LOAD, 16383, 8'h80, 8'h01, 8'h7f, 0, 0, 0, 0));
        send_item(make_item(OP_LOAD, 14'h2aaa, 8'haa, 8'h55, 8'h0f, 7'h55, 7'h2a, 7'h55, 7'h2a));
        send_item(make_item(OP_LOAD, 14'h1555, 8'h55, 8'haa, 8'hf0, 7'h2a, 7'h55, 7'h2a, 7'h55));
        send_item(make_item(OP_LOAD, 129, 10, 200, 30, 0, 0, 0, 0));
        // empty rectangle, then a single pixel
        send_item(make_item(OP_MUTATE, 0, 255, 255, 255, 0, 0, 0, 0));
        send_item(make_item(OP_MUTATE, 0, 255, 255, 255, 0, 0, 1, 1));
        send_item(make_item(OP_READ, 0, 0, 0, 0, 0, 0, 0, 0));
        // rectangles running past the right and bottom edges
        send_item(make_item(OP_MUTATE, 0, 8'h80, 8'h40, 8'h20, 120, 125, 20, 10));
        send_item(make_item(OP_MUTATE, 0, 8'h7f, 8'hfe, 8'h01, 127, 127, 127, 127));
        send_item(make_item(OP_READ, 16383, 0, 0, 0, 0, 0, 0, 0));
        // zero width with nonzero height
        send_item(make_item(OP_MUTATE, 0, 255, 0, 255, 0, 0, 0, 5));
        send_item(make_item(OP_MUTATE, 0, 10, 200, 30, 1, 1, 2, 2));
        send_item(make_item(OP_READ, 129, 0, 0, 0, 0, 0, 0, 0));
        // almost the whole image, short of the last row and column
        send_item(make_item(OP_MUTATE, 0, 0, 0, 0, 0, 0, 127, 127));
        send_item(make_item(OP_READ, 14'h2aaa, 0, 0, 0, 0, 0, 0, 0));
        send_item(make_item(OP_MUTATE, 0, 8'haa, 8'h55, 8'h0f, 7'h55, 7'h2a, 7'h2a, 7'h55));
        send_item(make_item(OP_READ, 14'h1555, 0, 0, 0, 0, 0, 0, 0));
        send_item(make_item(OP_NOP, 0, 0, 0, 0, 0, 0, 0, 0));
        drain_results();

        // nothing can beat a zero grade; sender idles
        write_grade('0);
        send_idle_pct = 72;
        run_random(25, 1'b1);
        drain_results();

        // top of range; receiver stalls
        write_grade(24'd12533760);
        send_idle_pct = 0;
        stall_pct     = 72;
        focus_x = $urandom_range(0, 119);
        focus_y = $urandom_range(0, 119);
        run_random(25, 1'b1);
        drain_results();

        // both sides idle now and then
        write_grade(24'h7fffff);
        send_idle_pct = 20;
        stall_pct     = 20;
        run_random(25, 1'b1);
        drain_results();

        // long receiver hold-off while beats keep coming
        send_idle_pct = 0;
        stall_pct     = 0;
        hold_request  = 400;
        run_random(12, 1'b0);
        drain_results();

        // random starting grade, no idling
        write_grade(GRADE_W'($urandom_range(0, 12533760)));
        run_random(10, 1'b1);
        drain_results();

        repeat (20) @(negedge clk);
        if (mismatch_count == 0 && results_owed == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule
